@@ rtl/qjmt_pkg.sv @@
// Shared types, widths and helpers of the quintic trajectory coefficient solver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qjmt_pkg;

	localparam int IN_FRAC_DEF  = 16;
	localparam int OUT_FRAC_DEF = 24;

	localparam int IN_W    = 32;
	localparam int DUR_W   = 24;
	localparam int COEFF_W = 48;

	// Quotient bits produced by the divider: magnitude, one rounding bit, one guard bit
	localparam int QUOT_BITS = COEFF_W + 2;
	// Divider register depth: entry stage, one stage per quotient bit, rounding stage
	localparam int DIV_LAT   = QUOT_BITS + 2;

	localparam logic signed [63:0] COEFF_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] COEFF_LO = 64'shFFFF_8000_0000_0000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DUR = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef struct packed {
		logic [COEFF_W-1:0] c0;
		logic [COEFF_W-1:0] c1;
		logic [COEFF_W-1:0] c2;
		logic               sat;
		logic               zero;
	} side_t;

	// Scale by a power of two: shift up, or round down to nearest with ties away from zero
	function automatic logic signed [63:0] scale_pow2(input logic signed [IN_W-1:0] v,
			input int up, input int dn);
		logic [63:0] mag;
		logic        neg;
		neg = v[IN_W-1];
		mag = neg ? (~64'(v) + 64'd1) : 64'(unsigned'(v));
		if (up > 0) begin
			mag = mag << up;
		end else if (dn > 0) begin
			mag = (mag + (64'd1 << (dn - 1))) >> dn;
		end
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// Clamp to the signed coefficient range; the top bit flags a clamp
	function automatic logic [COEFF_W:0] sat_coeff(input logic signed [63:0] v);
		logic [COEFF_W:0] r;
		if (v > COEFF_HI) begin
			r = {1'b1, COEFF_HI[COEFF_W-1:0]};
		end else if (v < COEFF_LO) begin
			r = {1'b1, COEFF_LO[COEFF_W-1:0]};
		end else begin
			r = {1'b0, v[COEFF_W-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/qjmt_req_if.sv @@
// Request channel of the coefficient solver: boundary states and duration.
// Depends on qjmt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qjmt_req_if;
	import qjmt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  start_pos;
	logic signed [IN_W-1:0]  start_vel;
	logic signed [IN_W-1:0]  start_acc;
	logic signed [IN_W-1:0]  end_pos;
	logic signed [IN_W-1:0]  end_vel;
	logic signed [IN_W-1:0]  end_acc;
	logic        [DUR_W-1:0] duration;

	modport source(output valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, input ready);
	modport sink(input valid, start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
		duration, output ready);
endinterface

`default_nettype wire

@@ rtl/qjmt_rsp_if.sv @@
// Response channel of the coefficient solver: six coefficients and a status code.
// Depends on qjmt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qjmt_rsp_if;
	import qjmt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COEFF_W-1:0] coeff_const;
	logic signed [COEFF_W-1:0] coeff_lin;
	logic signed [COEFF_W-1:0] coeff_sq;
	logic signed [COEFF_W-1:0] coeff_cube;
	logic signed [COEFF_W-1:0] coeff_quart;
	logic signed [COEFF_W-1:0] coeff_quint;
	logic        [1:0]         status;

	modport source(output valid, coeff_const, coeff_lin, coeff_sq, coeff_cube, coeff_quart,
		coeff_quint, status, input ready);
	modport sink(input valid, coeff_const, coeff_lin, coeff_sq, coeff_cube, coeff_quart,
		coeff_quint, status, output ready);
endinterface

`default_nettype wire

@@ rtl/qjmt_mul.sv @@
// Two-stage multiplier: signed operand times the unsigned duration, in 24-bit partials.
// Depends on qjmt_pkg for the duration width.
`timescale 1ns / 1ps
`default_nettype none

module qjmt_mul #(
	parameter int AW = 32
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [AW-1:0]                   a,
	input  logic        [qjmt_pkg::DUR_W-1:0]      b,
	output logic signed [AW+qjmt_pkg::DUR_W-1:0]   p
);
	import qjmt_pkg::*;

	localparam int CW  = DUR_W;
	localparam int NC  = (AW + CW - 1) / CW;
	localparam int EW  = NC * CW;
	localparam int PPW = 2 * CW + 1;
	localparam int SW  = EW + CW + 1;

	logic signed [EW-1:0]  ae;
	logic signed [PPW-1:0] pp_s1 [NC];
	logic signed [SW-1:0]  acc;

	assign ae = EW'(a);

	for (genvar c = 0; c < NC; c++) begin : g_part
		logic        [CW-1:0]  ch;
		logic signed [PPW-1:0] ta;
		logic signed [PPW-1:0] tb;
		assign ch = ae[c*CW +: CW];
		// only the top chunk carries the sign
		assign ta = (c == NC - 1) ? $signed({{(CW+1){ch[CW-1]}}, ch})
		                          : $signed({{(CW+1){1'b0}}, ch});
		assign tb = $signed({{(CW+1){1'b0}}, b});
		always_ff @(posedge clk) begin
			if (en) pp_s1[c] <= ta * tb;
		end
	end

	always_comb begin
		acc = '0;
		for (int c = 0; c < NC; c++) begin
			acc = acc + (SW'(pp_s1[c]) <<< (c * CW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) p <= acc[AW+CW-1:0];
	end
endmodule

`default_nettype wire

@@ rtl/qjmt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with rounding and clamp.
// Depends on qjmt_pkg for the coefficient width and quotient depth.
`timescale 1ns / 1ps
`default_nettype none

module qjmt_div #(
	parameter int NW = 120,
	parameter int DW = 72
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic        [NW-1:0]                 num2,
	input  logic        [DW-1:0]                 den,
	input  logic                                 neg,
	output logic signed [qjmt_pkg::COEFF_W-1:0]  quot,
	output logic                                 sat
);
	import qjmt_pkg::*;

	localparam int QB = QUOT_BITS;
	localparam int RW = (NW > DW + QB + 1) ? NW : DW + QB + 1;

	logic [RW-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];

	// entry: a quotient of 2^QB or more cannot fit, flag it up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num2);
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= RW'(num2) >= (RW'(den) << QB);
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_bit
		localparam int B = QB - i;
		logic [RW-1:0] dsh;
		logic          take;
		assign dsh  = RW'(den_s[i-1]) << B;
		assign take = rem_s[i-1] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? (rem_s[i-1] - dsh) : rem_s[i-1];
				quo_s[i] <= quo_s[i-1] | (QB'(take) << B);
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	logic [QB:0]        rnd;
	logic [QB-1:0]      mag;
	logic [QB-1:0]      lim;
	logic               over;
	logic [QB-1:0]      magc;
	logic [COEFF_W-1:0] mneg;

	// floor(2N/D) plus one, halved, rounds N/D to nearest with ties away from zero
	always_comb begin
		rnd  = {1'b0, quo_s[QB]} + (QB+1)'(1);
		mag  = rnd[QB:1];
		lim  = neg_s[QB] ? (QB'(1) << (COEFF_W - 1)) : ((QB'(1) << (COEFF_W - 1)) - QB'(1));
		over = ovf_s[QB] || (mag > lim);
		magc = over ? lim : mag;
		mneg = -magc[COEFF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot <= neg_s[QB] ? $signed(mneg) : $signed(magc[COEFF_W-1:0]);
			sat  <= over;
		end
	end
endmodule

`default_nettype wire

@@ rtl/quintic_jmt_coefficient_solver.sv @@
// Minimum-jerk quintic coefficient solver: six polynomial coefficients per transaction.
// Throughput one per cycle while no response is held at the output. Depth: 61 register
// stages, 9 front stages (capture, products, boundary residuals, numerators) plus 52
// divider stages.
// All stages advance together; a response held at the output stalls the whole pipe.
// arst_n clears only the stage valid bits; payload registers are not reset.
// Depends on qjmt_pkg, qjmt_req_if, qjmt_rsp_if, qjmt_mul and qjmt_div.
`timescale 1ns / 1ps
`default_nettype none

module quintic_jmt_coefficient_solver #(
	parameter int IN_FRAC_BITS  = qjmt_pkg::IN_FRAC_DEF,
	parameter int OUT_FRAC_BITS = qjmt_pkg::OUT_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qjmt_req_if.sink   req,
	qjmt_rsp_if.source rsp
);
	import qjmt_pkg::*;

	localparam int F   = IN_FRAC_BITS;
	localparam int G   = OUT_FRAC_BITS;
	localparam int LAT = 9 + DIV_LAT;

	// working width of the boundary residuals X, Y, Z
	localparam int MW_A = 2 * F + 36;
	localparam int MW_B = F + 60;
	localparam int MW_AB = (MW_A > MW_B) ? MW_A : MW_B;
	localparam int MW   = (MW_AB > 84) ? MW_AB : 84;
	// width of the combined numerators before their power-of-two scaling
	localparam int QW   = MW + 7;
	localparam int NW3  = QW + G - 2;
	localparam int NW4  = QW + F + G - 2;
	localparam int NW5  = QW + 2 * F + G - 2;
	localparam int DW3  = 3 * DUR_W;
	localparam int DW4  = 4 * DUR_W;
	localparam int DW5  = 5 * DUR_W;

	localparam int UP01 = (G > F) ? G - F : 0;
	localparam int DN01 = (F > G) ? F - G : 0;
	localparam int UP2  = (G > F + 1) ? G - F - 1 : 0;
	localparam int DN2  = (F + 1 > G) ? F + 1 - G : 0;

	logic en;
	logic vld_s [1:LAT];

	// Global advance: move every stage when the output is empty or being taken
	assign en        = !vld_s[LAT] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= req.valid;
			for (int k = 2; k <= LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Stage 1: capture the transaction, form the end-minus-start differences
	logic signed [IN_W-1:0]  s0_s1, s1_s1, s2_s1;
	logic signed [IN_W:0]    d0_s1, d1_s1, d2_s1;
	logic        [DUR_W-1:0] u_s [1:7];

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s1  <= req.start_pos;
			s1_s1  <= req.start_vel;
			s2_s1  <= req.start_acc;
			d0_s1  <= (IN_W+1)'(req.end_pos) - (IN_W+1)'(req.start_pos);
			d1_s1  <= (IN_W+1)'(req.end_vel) - (IN_W+1)'(req.start_vel);
			d2_s1  <= (IN_W+1)'(req.end_acc) - (IN_W+1)'(req.start_acc);
			u_s[1] <= req.duration;
			for (int k = 2; k <= 7; k++) u_s[k] <= u_s[k-1];
		end
	end

	// Low coefficients need only a power-of-two scale; compute them now and carry them
	side_t            side_d;
	side_t            side_s [2:LAT];
	logic [COEFF_W:0] c0_r, c1_r, c2_r;

	always_comb begin
		c0_r        = sat_coeff(scale_pow2(s0_s1, UP01, DN01));
		c1_r        = sat_coeff(scale_pow2(s1_s1, UP01, DN01));
		c2_r        = sat_coeff(scale_pow2(s2_s1, UP2, DN2));
		side_d.c0   = c0_r[COEFF_W-1:0];
		side_d.c1   = c1_r[COEFF_W-1:0];
		side_d.c2   = c2_r[COEFF_W-1:0];
		side_d.sat  = c0_r[COEFF_W] | c1_r[COEFF_W] | c2_r[COEFF_W];
		side_d.zero = (u_s[1] == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[2] <= side_d;
			for (int k = 3; k <= LAT; k++) side_s[k] <= side_s[k-1];
		end
	end

	// Stages 2-3: first round of products by T
	logic signed [DUR_W:0]          ue_s1;
	logic signed [IN_W+DUR_W-1:0]   s1u_s3, s2u_s3;
	logic signed [IN_W+DUR_W:0]     d1u_s3, d2u_s3;
	logic signed [2*DUR_W:0]        uu_s3;

	assign ue_s1 = $signed({1'b0, u_s[1]});

	qjmt_mul #(.AW(IN_W))    u_mul_s1u (.clk, .en, .a(s1_s1), .b(u_s[1]), .p(s1u_s3));
	qjmt_mul #(.AW(IN_W))    u_mul_s2u (.clk, .en, .a(s2_s1), .b(u_s[1]), .p(s2u_s3));
	qjmt_mul #(.AW(IN_W+1))  u_mul_d1u (.clk, .en, .a(d1_s1), .b(u_s[1]), .p(d1u_s3));
	qjmt_mul #(.AW(IN_W+1))  u_mul_d2u (.clk, .en, .a(d2_s1), .b(u_s[1]), .p(d2u_s3));
	qjmt_mul #(.AW(DUR_W+1)) u_mul_uu  (.clk, .en, .a(ue_s1), .b(u_s[1]), .p(uu_s3));

	// Stages 4-5: acceleration terms times T^2, and T^3
	logic signed [IN_W+2*DUR_W-1:0] s2uu_s5;
	logic signed [IN_W+2*DUR_W:0]   d2uu_s5;
	logic signed [3*DUR_W:0]        u3_s5;

	qjmt_mul #(.AW(IN_W+DUR_W))   u_mul_s2uu (.clk, .en, .a(s2u_s3), .b(u_s[3]), .p(s2uu_s5));
	qjmt_mul #(.AW(IN_W+DUR_W+1)) u_mul_d2uu (.clk, .en, .a(d2u_s3), .b(u_s[3]), .p(d2uu_s5));
	qjmt_mul #(.AW(2*DUR_W+1))    u_mul_u3   (.clk, .en, .a(uu_s3), .b(u_s[3]), .p(u3_s5));

	// Stages 6-9: T^4 and T^5 for the higher divisors
	logic signed [4*DUR_W:0] u4_s7;
	logic signed [5*DUR_W:0] u5_s9;

	qjmt_mul #(.AW(3*DUR_W+1)) u_mul_u4 (.clk, .en, .a(u3_s5), .b(u_s[5]), .p(u4_s7));
	qjmt_mul #(.AW(4*DUR_W+1)) u_mul_u5 (.clk, .en, .a(u4_s7), .b(u_s[7]), .p(u5_s9));

	// Align the first-order terms with the T^2 products
	logic signed [IN_W:0]         d0_s2, d0_s3, d0_s4, d0_s5;
	logic signed [IN_W+DUR_W-1:0] s1u_s4, s1u_s5;
	logic signed [IN_W+DUR_W:0]   d1u_s4, d1u_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s2  <= d0_s1;
			d0_s3  <= d0_s2;
			d0_s4  <= d0_s3;
			d0_s5  <= d0_s4;
			s1u_s4 <= s1u_s3;
			s1u_s5 <= s1u_s4;
			d1u_s4 <= d1u_s3;
			d1u_s5 <= d1u_s4;
		end
	end

	// Stage 6: boundary residuals scaled by 2^(3F+1)
	//   X = B0, Y = B1*T, Z = B2*T^2
	logic signed [MW-1:0] x_s6, y_s6, z_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6 <= (MW'(d0_s5) <<< (2 * F + 1)) - (MW'(s1u_s5) <<< (F + 1)) - MW'(s2uu_s5);
			y_s6 <= (MW'(d1u_s5) <<< (F + 1)) - (MW'(s2uu_s5) <<< 1);
			z_s6 <= MW'(d2uu_s5) <<< 1;
		end
	end

	// Stage 7: numerators of the top three coefficients
	//   a3: 20X - 8Y + Z,  a4: -30X + 14Y - 2Z,  a5: 12X - 6Y + Z
	logic signed [QW-1:0] xe, ye, ze;
	logic signed [QW-1:0] q3_s7, q4_s7, q5_s7;

	assign xe = QW'(x_s6);
	assign ye = QW'(y_s6);
	assign ze = QW'(z_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			q3_s7 <= (xe <<< 4) + (xe <<< 2) - (ye <<< 3) + ze;
			q4_s7 <= (xe <<< 1) - (xe <<< 5) + (ye <<< 4) - (ye <<< 1) - (ze <<< 1);
			q5_s7 <= (xe <<< 3) + (xe <<< 2) - (ye <<< 2) - (ye <<< 1) + ze;
		end
	end

	// Stages 8-9: split into sign and magnitude, hold for T^5
	logic signed [QW-1:0] q3n, q4n, q5n;
	logic [QW-2:0]        mag3_s8, mag4_s8, mag5_s8, mag3_s9, mag4_s9, mag5_s9;
	logic                 neg3_s8, neg4_s8, neg5_s8, neg3_s9, neg4_s9, neg5_s9;
	logic signed [3*DUR_W:0] u3_s6, u3_s7, u3_s8, u3_s9;
	logic signed [4*DUR_W:0] u4_s8, u4_s9;

	assign q3n = -q3_s7;
	assign q4n = -q4_s7;
	assign q5n = -q5_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			neg3_s8 <= q3_s7[QW-1];
			neg4_s8 <= q4_s7[QW-1];
			neg5_s8 <= q5_s7[QW-1];
			mag3_s8 <= q3_s7[QW-1] ? q3n[QW-2:0] : q3_s7[QW-2:0];
			mag4_s8 <= q4_s7[QW-1] ? q4n[QW-2:0] : q4_s7[QW-2:0];
			mag5_s8 <= q5_s7[QW-1] ? q5n[QW-2:0] : q5_s7[QW-2:0];
			neg3_s9 <= neg3_s8;
			neg4_s9 <= neg4_s8;
			neg5_s9 <= neg5_s8;
			mag3_s9 <= mag3_s8;
			mag4_s9 <= mag4_s8;
			mag5_s9 <= mag5_s8;
			u3_s6   <= u3_s5;
			u3_s7   <= u3_s6;
			u3_s8   <= u3_s7;
			u3_s9   <= u3_s8;
			u4_s8   <= u4_s7;
			u4_s9   <= u4_s8;
		end
	end

	// Stages 10-61: three dividers; twice the scaled numerator over T^3, T^4, T^5
	logic signed [COEFF_W-1:0] c3_q, c4_q, c5_q;
	logic                      sat3_q, sat4_q, sat5_q;

	qjmt_div #(.NW(NW3), .DW(DW3)) u_div3 (
		.clk, .en,
		.num2(NW3'(mag3_s9) << (G - 1)),
		.den(u3_s9[DW3-1:0]), .neg(neg3_s9),
		.quot(c3_q), .sat(sat3_q)
	);

	qjmt_div #(.NW(NW4), .DW(DW4)) u_div4 (
		.clk, .en,
		.num2(NW4'(mag4_s9) << (F + G - 1)),
		.den(u4_s9[DW4-1:0]), .neg(neg4_s9),
		.quot(c4_q), .sat(sat4_q)
	);

	qjmt_div #(.NW(NW5), .DW(DW5)) u_div5 (
		.clk, .en,
		.num2(NW5'(mag5_s9) << (2 * F + G - 1)),
		.den(u5_s9[DW5-1:0]), .neg(neg5_s9),
		.quot(c5_q), .sat(sat5_q)
	);

	// Output: zero duration drops every coefficient and overrides the clamp flag
	status_t st;
	logic    zero_o;

	assign zero_o = side_s[LAT].zero;

	always_comb begin
		if (zero_o) begin
			st = ST_ZERO_DUR;
		end else if (side_s[LAT].sat || sat3_q || sat4_q || sat5_q) begin
			st = ST_SAT;
		end else begin
			st = ST_OK;
		end
	end

	assign rsp.valid       = vld_s[LAT];
	assign rsp.status      = st;
	assign rsp.coeff_const = zero_o ? '0 : $signed(side_s[LAT].c0);
	assign rsp.coeff_lin   = zero_o ? '0 : $signed(side_s[LAT].c1);
	assign rsp.coeff_sq    = zero_o ? '0 : $signed(side_s[LAT].c2);
	assign rsp.coeff_cube  = zero_o ? '0 : c3_q;
	assign rsp.coeff_quart = zero_o ? '0 : c4_q;
	assign rsp.coeff_quint = zero_o ? '0 : c5_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_s[1])
		else $error("accepted transaction did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAT] && !en) |=> vld_s[LAT])
		else $error("stalled response was dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_ZERO_DUR ||
		               rsp.status == ST_SAT))
		else $error("undefined status code");

	a_zero_dur: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_ZERO_DUR) |->
		(rsp.coeff_const == '0 && rsp.coeff_quint == '0 && rsp.coeff_cube == '0))
		else $error("zero duration response carries nonzero coefficients");
endmodule

`default_nettype wire

@@ dv/qjmt_coeff_checker.sv @@
// Checker for the quintic coefficient solver: watches both channels, computes the
// expected coefficients of each accepted request and compares responses in order.
// Depends on qjmt_pkg, qjmt_req_if and qjmt_rsp_if.
`timescale 1ns / 1ps

module qjmt_coeff_checker (
	input  logic  clk,
	input  logic  arst_n,
	qjmt_req_if   req,
	qjmt_rsp_if   rsp,
	output int    errors,
	output int    pending
);
	import qjmt_pkg::*;

	localparam int FB = IN_FRAC_DEF;
	localparam int OB = OUT_FRAC_DEF;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic [COEFF_W-1:0] c0;
		logic [COEFF_W-1:0] c1;
		logic [COEFF_W-1:0] c2;
		logic [COEFF_W-1:0] c3;
		logic [COEFF_W-1:0] c4;
		logic [COEFF_W-1:0] c5;
		status_t            st;
	} coeffs_t;

	coeffs_t coeff_q[$];

	// Round num/den to nearest, ties away from zero, clamp to 48 bits; top bit flags a clamp
	function automatic logic [COEFF_W:0] round_div(input wide_t num, input wide_t den);
		logic [255:0] mag, quo, rem, lim;
		logic neg, clamp;
		neg   = num[255];
		mag   = neg ? -num : num;
		quo   = mag / den;
		rem   = mag % den;
		clamp = 1'b0;
		if ((rem << 1) >= den) quo = quo + 1;
		lim = neg ? (256'd1 << (COEFF_W - 1)) : ((256'd1 << (COEFF_W - 1)) - 1);
		if (quo > lim) begin
			quo   = lim;
			clamp = 1'b1;
		end
		if (neg) quo = -quo;
		return {clamp, quo[COEFF_W-1:0]};
	endfunction

	function automatic coeffs_t solve_coeffs(input logic signed [31:0] sp, sv, sa, ep, ev, ea,
			input logic [DUR_W-1:0] dur);
		coeffs_t r;
		wide_t s0, s1, s2, e0, e1, e2, u, sauu, x, y, z, num, den;
		logic [COEFF_W:0] t;
		logic clamp;
		int cx[3], cy[3], cz[3];
		cx = '{20, -30, 12};
		cy = '{-8, 14, -6};
		cz = '{1, -2, 1};
		r = '0;
		if (dur == 0) begin
			r.st = ST_ZERO_DUR;
			return r;
		end
		s0 = sp; s1 = sv; s2 = sa; e0 = ep; e1 = ev; e2 = ea;
		u  = wide_t'({232'd0, dur});
		clamp = 1'b0;
		t = round_div(s0 <<< OB, wide_t'(1) <<< FB);       clamp |= t[COEFF_W]; r.c0 = t[COEFF_W-1:0];
		t = round_div(s1 <<< OB, wide_t'(1) <<< FB);       clamp |= t[COEFF_W]; r.c1 = t[COEFF_W-1:0];
		t = round_div(s2 <<< OB, wide_t'(1) <<< (FB + 1)); clamp |= t[COEFF_W]; r.c2 = t[COEFF_W-1:0];
		// Boundary residuals scaled by 2^(3F+1)
		sauu = s2 * u * u;
		x = ((e0 - s0) <<< (2 * FB + 1)) - ((s1 * u) <<< (FB + 1)) - sauu;
		y = (((e1 - s1) * u) <<< (FB + 1)) - (sauu <<< 1);
		z = ((e2 - s2) * u * u) <<< 1;
		den = u * u * u;
		for (int j = 0; j < 3; j++) begin
			num = x * wide_t'(cx[j]) + y * wide_t'(cy[j]) + z * wide_t'(cz[j]);
			num = num <<< (j * FB + OB - 2);
			t = round_div(num, den);
			clamp |= t[COEFF_W];
			case (j)
				0: r.c3 = t[COEFF_W-1:0];
				1: r.c4 = t[COEFF_W-1:0];
				default: r.c5 = t[COEFF_W-1:0];
			endcase
			den = den * u;
		end
		r.st = clamp ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [COEFF_W-1:0] exp_v,
			input logic [COEFF_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		coeffs_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				coeff_q.insert(coeff_q.size(), solve_coeffs(req.start_pos, req.start_vel,
					req.start_acc, req.end_pos, req.end_vel, req.end_acc, req.duration));
			if (rsp.valid && rsp.ready) begin
				if (coeff_q.size() == 0) begin
					$display("%0t: response with no request outstanding", $time);
					errors++;
				end else begin
					want = coeff_q.pop_front();
					check_field("coeff_const", want.c0, rsp.coeff_const);
					check_field("coeff_lin", want.c1, rsp.coeff_lin);
					check_field("coeff_sq", want.c2, rsp.coeff_sq);
					check_field("coeff_cube", want.c3, rsp.coeff_cube);
					check_field("coeff_quart", want.c4, rsp.coeff_quart);
					check_field("coeff_quint", want.c5, rsp.coeff_quint);
					check_field("status", COEFF_W'(want.st), COEFF_W'(rsp.status));
				end
			end
			pending <= coeff_q.size();
		end
	end

endmodule

@@ dv/tb_quintic_jmt_coefficient_solver.sv @@
// Top of the quintic coefficient solver bench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on qjmt_coeff_checker and the RTL.
`timescale 1ns / 1ps

module tb_quintic_jmt_coefficient_solver;
	import qjmt_pkg::*;

	localparam int N_RANDOM   = 1500;
	localparam int DRAIN_WAIT = 70;
	localparam int STALL_MAX  = 5000;  // cycles with no transaction before giving up

	logic clk;
	logic arst_n;
	logic quiet;       // suppress idling on both sides
	int   errors;
	int   pending;
	int   stall_cnt;

	qjmt_req_if req ();
	qjmt_rsp_if rsp ();

	quintic_jmt_coefficient_solver i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	qjmt_coeff_checker i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.errors (errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Drive known values before the first edge
	initial begin
		arst_n        = 1'b0;
		quiet         = 1'b0;
		req.valid     = 1'b0;
		req.start_pos = '0;
		req.start_vel = '0;
		req.start_acc = '0;
		req.end_pos   = '0;
		req.end_vel   = '0;
		req.end_acc   = '0;
		req.duration  = '0;
		rsp.ready     = 1'b0;
	end

	// Back-pressure: drop ready on about 15 percent of cycles unless quiet
	always @(posedge clk) begin
		rsp.ready <= quiet || ($urandom_range(99) >= 15);
	end

	// Watchdog: abort after a long stretch with no transaction on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("tb_quintic_jmt_coefficient_solver: done, errors");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// Present one request, idling first at random, and hold it until accepted
	task automatic send_solve(input logic signed [31:0] sp, sv, sa, ep, ev, ea,
			input logic [DUR_W-1:0] dur);
		if (!quiet && $urandom_range(99) < 15) begin
			req.valid <= 1'b0;
			do @(posedge clk); while (!quiet && $urandom_range(99) < 15);
		end
		req.valid     <= 1'b1;
		req.start_pos <= sp;
		req.start_vel <= sv;
		req.start_acc <= sa;
		req.end_pos   <= ep;
		req.end_vel   <= ev;
		req.end_acc   <= ea;
		req.duration  <= dur;
		do @(posedge clk); while (!req.ready);
	endtask

	// Q16.16 value: full range, modest magnitudes, or an extreme
	function automatic logic [31:0] rand_q16();
		logic [31:0] v;
		case ($urandom_range(5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 32'h0010_0000);
			3: v = $urandom_range(0, 32'h0100_0000);
			4: v = -$urandom_range(0, 32'h0100_0000);
			default: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0000_0001;
					default: v = '0;
				endcase
			end
		endcase
		return v;
	endfunction

	// Duration: mostly realistic seconds, some tiny, some full range, rarely zero
	function automatic logic [DUR_W-1:0] rand_dur();
		int sel;
		sel = $urandom_range(19);
		if (sel < 12) return DUR_W'($urandom_range(32'h0000_4000, 32'h000A_0000));
		if (sel < 15) return DUR_W'($urandom_range(1, 255));
		if (sel < 19) return DUR_W'($urandom_range(1, 32'h00FF_FFFF));
		return '0;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: trivial, typical, zero duration, extremes of every field, saturation
		send_solve(0, 0, 0, 0, 0, 0, 24'h01_0000);
		send_solve(0, 0, 0, 32'h000A_0000, 0, 0, 24'h02_0000);
		send_solve(32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000, 32'h0064_0000,
			32'h0014_0000, 32'h0000_8000, 24'h05_4000);
		send_solve(32'h1234_5678, 32'h0100_0000, 32'h0000_0003, 32'h0200_0000, 0, 0, 24'h0);
		send_solve(0, 0, 0, 0, 0, 0, 24'h0);
		send_solve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
		send_solve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
		send_solve(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0001);
		send_solve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h00_0001);
		send_solve(0, 0, 0, 32'h0000_0001, 0, 0, 24'h00_0001);
		send_solve(0, 0, 0, 32'h0001_0000, 0, 0, 24'h00_0100);
		send_solve(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 24'h01_0000);
		send_solve(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 24'h01_0000);
		send_solve(0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 24'h01_0000);
		send_solve(0, 0, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
			24'h01_0000);
		send_solve(32'h0010_0000, 32'hFFF0_0000, 32'h0000_4000, 32'hFFE0_0000,
			32'h0008_0000, 32'hFFFF_C000, 24'h80_0000);
		send_solve(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 24'h00_0010);
		send_solve(0, 0, 0, 32'h8000_0000, 0, 0, 24'h00_0010);

		// Random solves; a quiet stretch in the middle, then one full drain
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 400 && n < 700);
			if (n == 900) begin
				req.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			send_solve(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
				rand_dur());
		end
		quiet = 1'b0;
		req.valid <= 1'b0;

		// Wait out the pipe, then hold a little longer for any stray response
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("tb_quintic_jmt_coefficient_solver: done, clean");
		end else begin
			$display("tb_quintic_jmt_coefficient_solver: done, errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/qjmt_pkg.sv
rtl/qjmt_req_if.sv
rtl/qjmt_rsp_if.sv
rtl/qjmt_mul.sv
rtl/qjmt_div.sv
rtl/quintic_jmt_coefficient_solver.sv
dv/qjmt_coeff_checker.sv
dv/tb_quintic_jmt_coefficient_solver.sv
